>>> rtl/djo_pkg.sv
`timescale 1ns / 1ps
// djo_pkg: widths, side-band types, reciprocal and arctangent tables, square root step
// no dependencies; imported by every module of the disk offset generator
package djo_pkg;

    localparam int NW            = 20;
    localparam int QW            = 16;
    localparam int RW            = 25;
    localparam int PW            = NW + RW;
    localparam int XW            = 27;
    localparam int ZW            = 25;
    localparam int AW            = 23;
    localparam int IW            = 22;
    localparam int FW            = 5;
    localparam int SQRT_STAGES   = 8;
    localparam int CORDIC_STAGES = 10;
    localparam logic [29:0] KGAIN = 30'd652032874;

    typedef struct packed {
        logic          err;
        logic [IW-1:0] idx;
    } side_t;

    typedef struct packed {
        logic [18:0] rem;
        logic [15:0] root;
    } sq_t;

    // floor(2^24 / f)
    function automatic logic [RW-1:0] recip(input logic [FW-1:0] f);
        logic [RW-1:0] r;
        case (f)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592405;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355443;
            5'd6:    r = 25'd2796202;
            5'd7:    r = 25'd2396745;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864135;
            5'd10:   r = 25'd1677721;
            5'd11:   r = 25'd1525201;
            5'd12:   r = 25'd1398101;
            5'd13:   r = 25'd1290555;
            5'd14:   r = 25'd1198372;
            5'd15:   r = 25'd1118481;
            5'd16:   r = 25'd1048576;
            5'd17:   r = 25'd986895;
            5'd18:   r = 25'd932067;
            5'd19:   r = 25'd883011;
            5'd20:   r = 25'd838860;
            5'd21:   r = 25'd798915;
            5'd22:   r = 25'd762600;
            5'd23:   r = 25'd729444;
            5'd24:   r = 25'd699050;
            5'd25:   r = 25'd671088;
            5'd26:   r = 25'd645277;
            5'd27:   r = 25'd621378;
            5'd28:   r = 25'd599186;
            5'd29:   r = 25'd578524;
            5'd30:   r = 25'd559240;
            5'd31:   r = 25'd541200;
            default: r = '0;
        endcase
        return r;
    endfunction

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic [AW-1:0] atan_turn(input logic [4:0] i);
        logic [AW-1:0] a;
        case (i)
            5'd0:    a = 23'd2097152;
            5'd1:    a = 23'd1238021;
            5'd2:    a = 23'd654136;
            5'd3:    a = 23'd332050;
            5'd4:    a = 23'd166669;
            5'd5:    a = 23'd83416;
            5'd6:    a = 23'd41718;
            5'd7:    a = 23'd20860;
            5'd8:    a = 23'd10430;
            5'd9:    a = 23'd5215;
            5'd10:   a = 23'd2608;
            5'd11:   a = 23'd1304;
            5'd12:   a = 23'd652;
            5'd13:   a = 23'd326;
            5'd14:   a = 23'd163;
            5'd15:   a = 23'd81;
            5'd16:   a = 23'd41;
            5'd17:   a = 23'd20;
            5'd18:   a = 23'd10;
            5'd19:   a = 23'd5;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
        logic [18:0] acc;
        logic [18:0] trial;
        sq_t         o;
        acc   = {s.rem[16:0], pair};
        trial = {1'b0, s.root, 2'b01};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[14:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[14:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> rtl/djo_div_fix.sv
`timescale 1ns / 1ps
// djo_div_fix: quotient correction after the reciprocal multiply
// depends on djo_pkg
module djo_div_fix
    import djo_pkg::*;
(
    input  logic [NW-1:0] num,
    input  logic [PW-1:0] prod,
    input  logic [FW-1:0] f,
    output logic [QW-1:0] quot
);
    logic [16:0] q0;
    logic [21:0] qf;
    logic [21:0] r;

    always_comb begin
        q0   = prod[40:24];
        qf   = 22'(q0) * 22'(f);
        r    = 22'(num) - qf;
        quot = (r >= 22'(f)) ? QW'(q0 + 17'd1) : q0[QW-1:0];
    end
endmodule

>>> rtl/djo_sqrt_stage.sv
`timescale 1ns / 1ps
// djo_sqrt_stage: two digit steps of the integer square root of y16 * 65536
// depends on djo_pkg
module djo_sqrt_stage
    import djo_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  sq_t           si,
    input  logic [QW-1:0] y16,
    output sq_t           so
);
    localparam int K1 = 15 - 2 * STAGE;
    localparam int K2 = 14 - 2 * STAGE;

    logic [31:0] rad;
    sq_t         mid;

    always_comb begin
        rad = {y16, 16'b0};
        mid = sqrt_step(si, rad[2*K1+1 -: 2]);
        so  = sqrt_step(mid, rad[2*K2+1 -: 2]);
    end
endmodule

>>> rtl/djo_cordic_stage.sv
`timescale 1ns / 1ps
// djo_cordic_stage: two rotation-mode cordic iterations
// depends on djo_pkg
module djo_cordic_stage
    import djo_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic signed [XW-1:0] xi,
    input  logic signed [XW-1:0] yi,
    input  logic signed [ZW-1:0] zi,
    output logic signed [XW-1:0] xo,
    output logic signed [XW-1:0] yo,
    output logic signed [ZW-1:0] zo
);
    localparam int I0 = 2 * STAGE;
    localparam int I1 = 2 * STAGE + 1;

    logic signed [XW-1:0] xm, ym;
    logic signed [ZW-1:0] zm;
    logic signed [ZW-1:0] a0, a1;

    always_comb begin
        a0 = signed'(ZW'(atan_turn(5'(I0))));
        a1 = signed'(ZW'(atan_turn(5'(I1))));
        if (zi >= 0) begin
            xm = xi - (yi >>> I0);
            ym = yi + (xi >>> I0);
            zm = zi - a0;
        end else begin
            xm = xi + (yi >>> I0);
            ym = yi - (xi >>> I0);
            zm = zi + a0;
        end
        if (zm >= 0) begin
            xo = xm - (ym >>> I1);
            yo = ym + (xm >>> I1);
            zo = zm - a1;
        end else begin
            xo = xm + (ym >>> I1);
            yo = ym - (xm >>> I1);
            zo = zm + a1;
        end
    end
endmodule

>>> rtl/jittered_disk_offset_generator.sv
`timescale 1ns / 1ps
// jittered_disk_offset_generator: stratified jittered polar disk sample offsets
// depends on djo_pkg, djo_div_fix, djo_sqrt_stage, djo_cordic_stage
// one request per cycle sustained while the output is not stalled; built from the
// 8-stage square root and 10-stage cordic pipelines (two steps each)
// reset: synchronous active-low aresetn clears all valid bits, filter_size returns to 4
module jittered_disk_offset_generator
    import djo_pkg::*;
#(
    parameter int PATTERN_WIDTH  = 128,
    parameter int PATTERN_HEIGHT = 128,
    parameter int MAX_FILTER     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_wdata,  // filter_size
    input  logic        s_tvalid,
    output logic        s_tready,
    // texel_x, texel_y, cell_u, cell_v, jitter_u, jitter_v
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // offset_x, offset_y, texel_index
    output logic        m_tuser     // cell_error
);
    localparam int PLANE = PATTERN_WIDTH * PATTERN_HEIGHT;

    logic [FW-1:0] fsize_reg;
    logic          en;

    // stage 1
    logic          v1_reg;
    logic [NW-1:0] nx1_reg, ny1_reg;
    logic [FW-1:0] f1_reg;
    logic          err1_reg;
    logic [8:0]    layer1_reg;
    logic [6:0]    tx1_reg, ty1_reg;
    // stage 2
    logic          v2_reg;
    logic [PW-1:0] px2_reg, py2_reg;
    logic [NW-1:0] nx2_reg, ny2_reg;
    logic [FW-1:0] f2_reg;
    side_t         sd2_reg;
    // stage 3
    logic          v3_reg;
    logic [QW-1:0] x3_reg, y3_reg;
    side_t         sd3_reg;
    // square root stages
    logic          sv_reg [SQRT_STAGES];
    sq_t           sq_reg [SQRT_STAGES];
    sq_t           sq_next[SQRT_STAGES];
    logic [QW-1:0] sx_reg [SQRT_STAGES];
    logic [QW-1:0] sy_reg [SQRT_STAGES];
    side_t         ss_reg [SQRT_STAGES];
    // gain multiply
    logic          vg_reg;
    logic [23:0]   xg_reg;
    logic signed [ZW-1:0] zg_reg;
    logic          ng_reg;
    side_t         sg_reg;
    // cordic start
    logic          vp_reg;
    logic signed [XW-1:0] xp_reg;
    logic signed [ZW-1:0] zp_reg;
    side_t         sp_reg;
    // cordic stages
    logic                 cv_reg [CORDIC_STAGES];
    logic signed [XW-1:0] cx_reg [CORDIC_STAGES];
    logic signed [XW-1:0] cy_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] cz_reg [CORDIC_STAGES];
    side_t                cs_reg [CORDIC_STAGES];
    logic signed [XW-1:0] cx_next[CORDIC_STAGES];
    logic signed [XW-1:0] cy_next[CORDIC_STAGES];
    logic signed [ZW-1:0] cz_next[CORDIC_STAGES];
    // output
    logic          vo_reg;
    logic [15:0]   ox_reg, oy_reg;
    logic [IW-1:0] oi_reg;
    logic          oe_reg;

    // input decode
    logic [6:0]    in_tx, in_ty;
    logic [3:0]    in_cu, in_cv;
    logic [15:0]   in_ju, in_jv;
    logic [FW-1:0] f_eff;
    logic [NW:0]   nx_next, ny_next;
    logic [QW-1:0] qx, qy;
    logic [23:0]   z24;
    logic signed [ZW-1:0] z_ext, z_fold;
    logic          z_neg;
    logic [45:0]   gprod;

    function automatic logic [15:0] sat_q15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        logic signed [17:0]   r;
        t = v + XW'(256);
        r = 18'(t >>> 9);
        if (r > 18'sd32767) return 16'h7FFF;
        if (r < -18'sd32768) return 16'h8000;
        return r[15:0];
    endfunction

    assign en        = !vo_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_tx   = s_tdata[6:0];
        in_ty   = s_tdata[13:7];
        in_cu   = s_tdata[17:14];
        in_cv   = s_tdata[21:18];
        in_ju   = s_tdata[37:22];
        in_jv   = s_tdata[53:38];
        f_eff   = (32'(fsize_reg) > MAX_FILTER) ? FW'(MAX_FILTER) : fsize_reg;
        nx_next = {1'b0, in_cu, 16'h8000} + {{5{in_ju[15]}}, in_ju};
        ny_next = {1'b0, in_cv, 16'h8000} + {{5{in_jv[15]}}, in_jv};
        z24     = {sx_reg[SQRT_STAGES-1], 8'b0};
        z_ext   = ZW'(signed'(z24));
        if (z_ext > 25'sd4194304) begin
            z_fold = z_ext - 25'sd8388608;
            z_neg  = 1'b1;
        end else if (z_ext < -25'sd4194304) begin
            z_fold = z_ext + 25'sd8388608;
            z_neg  = 1'b1;
        end else begin
            z_fold = z_ext;
            z_neg  = 1'b0;
        end
        gprod = sq_reg[SQRT_STAGES-1].root * KGAIN;
    end

    djo_div_fix u_div_x (.num(nx2_reg), .prod(px2_reg), .f(f2_reg), .quot(qx));
    djo_div_fix u_div_y (.num(ny2_reg), .prod(py2_reg), .f(f2_reg), .quot(qy));

    genvar g;
    generate
        for (g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
            if (g == 0) begin : g_first
                djo_sqrt_stage #(.STAGE(g)) u_sq (
                    .si('0), .y16(y3_reg), .so(sq_next[g]));
            end else begin : g_rest
                djo_sqrt_stage #(.STAGE(g)) u_sq (
                    .si(sq_reg[g-1]), .y16(sy_reg[g-1]), .so(sq_next[g]));
            end
        end
        for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
            if (g == 0) begin : g_first
                djo_cordic_stage #(.STAGE(g)) u_cs (
                    .xi(xp_reg), .yi('0), .zi(zp_reg),
                    .xo(cx_next[g]), .yo(cy_next[g]), .zo(cz_next[g]));
            end else begin : g_rest
                djo_cordic_stage #(.STAGE(g)) u_cs (
                    .xi(cx_reg[g-1]), .yi(cy_reg[g-1]), .zi(cz_reg[g-1]),
                    .xo(cx_next[g]), .yo(cy_next[g]), .zo(cz_next[g]));
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsize_reg <= 5'd4;
        end else if (cfg_valid) begin
            fsize_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vg_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i < SQRT_STAGES; i++) sv_reg[i] <= 1'b0;
            for (int i = 0; i < CORDIC_STAGES; i++) cv_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int i = 1; i < SQRT_STAGES; i++) sv_reg[i] <= sv_reg[i-1];
            vg_reg <= sv_reg[SQRT_STAGES-1];
            vp_reg <= vg_reg;
            cv_reg[0] <= vp_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) cv_reg[i] <= cv_reg[i-1];
            vo_reg <= cv_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx1_reg    <= nx_next[NW-1:0];
            ny1_reg    <= ny_next[NW-1:0];
            f1_reg     <= f_eff;
            err1_reg   <= ({1'b0, in_cu} >= f_eff) || ({1'b0, in_cv} >= f_eff);
            layer1_reg <= 9'(in_cv) * 9'(f_eff) + 9'(in_cu);
            tx1_reg    <= in_tx;
            ty1_reg    <= in_ty;

            px2_reg     <= nx1_reg * recip(f1_reg);
            py2_reg     <= ny1_reg * recip(f1_reg);
            nx2_reg     <= nx1_reg;
            ny2_reg     <= ny1_reg;
            f2_reg      <= f1_reg;
            sd2_reg.err <= err1_reg;
            sd2_reg.idx <= IW'(64'(layer1_reg) * 64'(PLANE)
                         + 64'(ty1_reg) * 64'(PATTERN_WIDTH) + 64'(tx1_reg));

            x3_reg  <= qx;
            y3_reg  <= qy;
            sd3_reg <= sd2_reg;

            sq_reg[0] <= sq_next[0];
            sx_reg[0] <= x3_reg;
            sy_reg[0] <= y3_reg;
            ss_reg[0] <= sd3_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                sq_reg[i] <= sq_next[i];
                sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1];
                ss_reg[i] <= ss_reg[i-1];
            end

            xg_reg <= gprod[45:22];
            ng_reg <= z_neg;
            zg_reg <= z_fold;
            sg_reg <= ss_reg[SQRT_STAGES-1];

            xp_reg <= ng_reg ? -signed'(XW'(xg_reg)) : signed'(XW'(xg_reg));
            zp_reg <= zg_reg;
            sp_reg <= sg_reg;

            cx_reg[0] <= cx_next[0];
            cy_reg[0] <= cy_next[0];
            cz_reg[0] <= cz_next[0];
            cs_reg[0] <= sp_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
                cs_reg[i] <= cs_reg[i-1];
            end

            oe_reg <= cs_reg[CORDIC_STAGES-1].err;
            if (cs_reg[CORDIC_STAGES-1].err) begin
                ox_reg <= '0;
                oy_reg <= '0;
                oi_reg <= '0;
            end else begin
                ox_reg <= sat_q15(cx_reg[CORDIC_STAGES-1]);
                oy_reg <= sat_q15(cy_reg[CORDIC_STAGES-1]);
                oi_reg <= cs_reg[CORDIC_STAGES-1].idx;
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {2'b00, oi_reg, oy_reg, ox_reg};
    assign m_tuser  = oe_reg;
endmodule

>>> verif/tb_jittered_disk_offset_generator.sv
`timescale 1ns / 1ps
// self-checking bench for jittered_disk_offset_generator: random and directed sample requests
// with an in-bench fixed-point disk offset predictor; depends on djo_pkg and the rtl top
module tb_jittered_disk_offset_generator;
    import djo_pkg::*;

    typedef struct packed {
        logic [15:0] jv;
        logic [15:0] ju;
        logic [3:0]  cv;
        logic [3:0]  cu;
        logic [6:0]  ty;
        logic [6:0]  tx;
    } sample_req_t;

    typedef struct {
        logic [15:0] ox;
        logic [15:0] oy;
        logic [21:0] idx;
        logic        err;
    } disk_offset_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    jittered_disk_offset_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    localparam longint ATAN_TBL [20] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
        41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

    logic [4:0]   filter_reg = 5'd4;
    sample_req_t  pending_reqs[$];
    disk_offset_t expected_offsets[$];
    int           errors = 0;
    bit           gaps_on = 1'b0;
    bit           hold_off = 1'b0;
    bit           hold_start = 1'b0;
    int           hold_cnt = 0;
    bit           in_fire = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] sat_q15(longint v);
        longint r;
        r = floor_shr(v + 256, 9);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint isqrt_fast(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic disk_offset_t predict_offset(sample_req_t r, logic [4:0] fs);
        disk_offset_t o;
        longint f, x16, y16, mag, cx, cy, z, dx, dy;
        f = (fs > 16) ? 16 : fs;
        o = '{16'd0, 16'd0, 22'd0, 1'b1};
        if (r.cu >= f || r.cv >= f) return o;
        x16 = (longint'(r.cu) * 65536 + 32768 + longint'($signed(r.ju))) / f;
        y16 = (longint'(r.cv) * 65536 + 32768 + longint'($signed(r.jv))) / f;
        mag = isqrt_fast(y16 << 16);
        cx = (mag * 652032874) >> 22;
        cy = 0;
        z = x16 * 256;
        if (z >= 8388608) z -= 16777216;
        if (z > 4194304) begin
            z -= 8388608;
            cx = -cx;
        end else if (z < -4194304) begin
            z += 8388608;
            cx = -cx;
        end
        for (int i = 0; i < 20; i++) begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= ATAN_TBL[i];
            end else begin
                cx += dx;
                cy -= dy;
                z += ATAN_TBL[i];
            end
        end
        o.ox  = sat_q15(cx);
        o.oy  = sat_q15(cy);
        o.idx = 22'((longint'(r.cv) * f + r.cu) * 16384 + longint'(r.ty) * 128 + r.tx);
        o.err = 1'b0;
        return o;
    endfunction

    // request driver
    always @(posedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            expected_offsets.push_back(predict_offset(sample_req_t'(s_tdata[53:0]), filter_reg));
            void'(pending_reqs.pop_front());
        end
    end

    always @(negedge aclk) begin
        if (pending_reqs.size() > 0
                && ((s_tvalid && !in_fire) || !(gaps_on && $urandom_range(99) < 15))) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {2'b00, pending_reqs[0]};
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= !hold_off && !(gaps_on && $urandom_range(99) < 15);
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_off = 1'b0;
        end else if (hold_start) begin
            hold_start = 1'b0;
            hold_cnt   = 200;
            hold_off   = 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        disk_offset_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_offsets.size() == 0) begin
                $display("%0t: unexpected result %h err %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = expected_offsets.pop_front();
                if (m_tdata[15:0] !== e.ox || m_tdata[31:16] !== e.oy
                        || m_tdata[53:32] !== e.idx || m_tuser !== e.err) begin
                    $display("%0t: expected x %h y %h idx %h err %b, got x %h y %h idx %h err %b",
                             $time, e.ox, e.oy, e.idx, e.err, m_tdata[15:0], m_tdata[31:16],
                             m_tdata[53:32], m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic sample_req_t rand_req(int fs);
        sample_req_t r;
        int lim;
        lim = (fs < 1) ? 0 : ((fs > 16) ? 15 : fs - 1);
        r.tx = 7'($urandom);
        r.ty = 7'($urandom);
        r.ju = 16'($urandom);
        r.jv = 16'($urandom);
        if ($urandom_range(9) == 0) begin
            r.cu = 4'($urandom);
            r.cv = 4'($urandom);
        end else begin
            r.cu = 4'($urandom_range(lim));
            r.cv = 4'($urandom_range(lim));
        end
        return r;
    endfunction

    task automatic set_filter(input logic [4:0] fs);
        while (pending_reqs.size() > 0 || expected_offsets.size() > 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= fs;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        filter_reg = fs;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    localparam logic [4:0] FILTER_SET [8] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd3, 5'd17, 5'd4};

    initial begin
        sample_req_t r;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // directed: extremes of jitter, cells and texel at reset filter size
        foreach (ATAN_TBL[i]) begin
            r.tx = (i % 2) ? 7'h7F : 7'h00;
            r.ty = (i % 3 == 0) ? 7'h7F : 7'h00;
            r.cu = 4'(i % 4);
            r.cv = 4'((i / 4) % 4);
            r.ju = (i % 2) ? 16'h7FFF : 16'h8000;
            r.jv = (i % 3 == 1) ? 16'h8000 : 16'h7FFF;
            pending_reqs.push_back(r);
        end
        r = '{16'h0000, 16'h0000, 4'hF, 4'hF, 7'h7F, 7'h7F};
        pending_reqs.push_back(r);
        r = '{16'h0000, 16'h0000, 4'h0, 4'h4, 7'h01, 7'h02};
        pending_reqs.push_back(r);
        r = '{16'h0000, 16'h0000, 4'h3, 4'h3, 7'h40, 7'h20};
        pending_reqs.push_back(r);
        gaps_on = 1'b1;
        foreach (FILTER_SET[p]) begin
            set_filter(FILTER_SET[p]);
            for (int k = 0; k < 160; k++) pending_reqs.push_back(rand_req(FILTER_SET[p]));
            if (p == 1) begin
                // long output hold-off so the pipeline fills and backs up
                hold_start = 1'b1;
            end
            if (p == 4) begin
                gaps_on = 1'b0;
                while (pending_reqs.size() > 0) @(negedge aclk);
                gaps_on = 1'b1;
            end
        end
        while (pending_reqs.size() > 0 || expected_offsets.size() > 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/djo_pkg.sv
rtl/djo_div_fix.sv
rtl/djo_sqrt_stage.sv
rtl/djo_cordic_stage.sv
rtl/jittered_disk_offset_generator.sv
verif/tb_jittered_disk_offset_generator.sv
